// ===== rtl/pairwise_range_neighbor_finder_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pair range neighbor finder
// Both macros sample on clk and are disabled during reset (rst_n low).
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_RANGE_NEIGHBOR_FINDER_MACROS_SVH
`define PAIRWISE_RANGE_NEIGHBOR_FINDER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PRNF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PRNF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/prnf_pkg.sv =====
// ----------------------------------------------------------------------------
// prnf_pkg
// Shared constants and types for the pair range neighbor finder.
// ----------------------------------------------------------------------------
`default_nettype none

package prnf_pkg;

    localparam int NUM_DRONES = 8;
    localparam int POS_BITS   = 24;

    localparam int ID_W      = 3;
    localparam int SEQ_W     = 32;
    localparam int IN_POS_W  = 24;
    localparam int RANGE_W   = 52;
    localparam int COUNT_W   = 4;
    localparam int DATA_W    = 64;
    localparam int ADDR_W    = 4;

    localparam int IDX_W = (NUM_DRONES > 1) ? $clog2(NUM_DRONES) : 1;
    localparam int CNT_W = $clog2(NUM_DRONES + 1);

    // |b - a| fits in POS_BITS unsigned bits
    localparam int DIFF_W = POS_BITS + 1;
    localparam int SQ_W   = 2 * POS_BITS;
    localparam int SUM_W  = SQ_W + 2;
    localparam int CMP_W  = (SUM_W > RANGE_W) ? SUM_W : RANGE_W;

    localparam logic [RANGE_W-1:0] RANGE_RESET = RANGE_W'(58982400);
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(8);

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // register select, taken from the 8-byte aligned address
    localparam logic REG_RANGE = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    typedef struct packed {
        logic                       opcode;
        logic [ID_W-1:0]            node_id;
        logic [SEQ_W-1:0]           msg_seq;
        logic signed [IN_POS_W-1:0] pos_x;
        logic signed [IN_POS_W-1:0] pos_y;
        logic signed [IN_POS_W-1:0] pos_z;
    } cmd_t;

    typedef struct packed {
        logic [ID_W-1:0] first_id;
        logic [ID_W-1:0] second_id;
        logic            pair_valid;
        logic            last;
    } res_t;

    typedef struct packed {
        logic signed [POS_BITS-1:0] x;
        logic signed [POS_BITS-1:0] y;
        logic signed [POS_BITS-1:0] z;
    } pos_t;

    // travels alongside a pair through the distance pipeline
    typedef struct packed {
        logic             live;
        logic             last;
        logic             both;
        logic [IDX_W-1:0] first;
        logic [IDX_W-1:0] second;
    } tag_t;

endpackage

`default_nettype wire

// ===== rtl/prnf_dist.sv =====
// ----------------------------------------------------------------------------
// prnf_dist
// Three-stage squared distance and range compare: |diff|, square, sum.
// ----------------------------------------------------------------------------
`default_nettype none

module prnf_dist (
    input  logic                             clk,
    input  logic                             rst_n,
    input  prnf_pkg::pos_t                   pos_a,
    input  prnf_pkg::pos_t                   pos_b,
    input  prnf_pkg::tag_t                   tag_in,
    input  logic [prnf_pkg::RANGE_W-1:0]     range_sq,
    output prnf_pkg::tag_t                   tag_out,
    output logic                             near
);

    logic signed [prnf_pkg::POS_BITS-1:0] a_ax [3];
    logic signed [prnf_pkg::POS_BITS-1:0] b_ax [3];
    logic signed [prnf_pkg::DIFF_W-1:0]   diff [3];
    logic signed [prnf_pkg::DIFF_W-1:0]   neg  [3];

    logic [prnf_pkg::POS_BITS-1:0] mag_reg [3];
    logic [prnf_pkg::SQ_W-1:0]     sq_reg  [3];
    logic [prnf_pkg::SUM_W-1:0]    sum;
    logic                          near_reg;

    prnf_pkg::tag_t tag1_reg, tag2_reg, tag3_reg;

    assign a_ax[0] = pos_a.x;
    assign a_ax[1] = pos_a.y;
    assign a_ax[2] = pos_a.z;
    assign b_ax[0] = pos_b.x;
    assign b_ax[1] = pos_b.y;
    assign b_ax[2] = pos_b.z;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            diff[k] = $signed({b_ax[k][prnf_pkg::POS_BITS-1], b_ax[k]})
                    - $signed({a_ax[k][prnf_pkg::POS_BITS-1], a_ax[k]});
            neg[k]  = -diff[k];
        end
    end

    assign sum = prnf_pkg::SUM_W'(sq_reg[0]) + prnf_pkg::SUM_W'(sq_reg[1])
               + prnf_pkg::SUM_W'(sq_reg[2]);

    // tags carry the live bit: reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            mag_reg[k] <= diff[k][prnf_pkg::DIFF_W-1] ? neg[k][prnf_pkg::POS_BITS-1:0]
                                                      : diff[k][prnf_pkg::POS_BITS-1:0];
            sq_reg[k]  <= prnf_pkg::SQ_W'(mag_reg[k]) * prnf_pkg::SQ_W'(mag_reg[k]);
        end
        near_reg <= prnf_pkg::CMP_W'(sum) <= prnf_pkg::CMP_W'(range_sq);
    end

    assign tag_out = tag3_reg;
    assign near    = near_reg;

endmodule

`default_nettype wire

// ===== rtl/pairwise_range_neighbor_finder.sv =====
// ----------------------------------------------------------------------------
// pairwise_range_neighbor_finder
// Position table with all-pairs fixed-radius neighbor scan.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low; cmd carries it.
//   Update request (opcode 0): writes one drone's x/y/z into the position
//   memory and sets its valid mark to (msg_seq != 0). It gives no result;
//   busy stays low.
//   Tick request (opcode 1): walks every pair i <= j over the first
//   min(active_count, NUM_DRONES) drones, one pair per cycle (the position
//   memory's two read ports feed one distance pipeline). Each in-range pair
//   of valid drones gives a result; a closing result with last=1 follows.
//   With P pairs (36 at eight drones) busy is high from the accepting edge
//   until the closing result appears, so the next request is taken only
//   after that closing result.
//   Results show on result for one cycle with result_strobe; the receiver
//   cannot stall them.
//   Config registers (APB, 64-bit data): range_squared at 0x0,
//   active_count at 0x8. Write only while idle.
//   Reset clears valid marks and control and loads the config defaults, but
//   not the position memory (an entry is only read as valid once written).
// ----------------------------------------------------------------------------
`default_nettype none

`include "pairwise_range_neighbor_finder_macros.svh"

module pairwise_range_neighbor_finder (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [prnf_pkg::ADDR_W-1:0]   paddr,
    input  logic [prnf_pkg::DATA_W-1:0]   pwdata,
    output logic [prnf_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // requests
    input  logic                          start,
    input  prnf_pkg::cmd_t                cmd,
    output logic                          busy,
    // results
    output logic                          result_strobe,
    output prnf_pkg::res_t                result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CLOSE,
        ST_WAIT
    } state_t;

    // ---------------- configuration registers ----------------
    logic [prnf_pkg::RANGE_W-1:0] range_reg;
    logic [prnf_pkg::COUNT_W-1:0] count_reg;
    logic                         cfg_wr;
    logic                         reg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign reg_sel = paddr[prnf_pkg::ADDR_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg <= prnf_pkg::RANGE_RESET;
            count_reg <= prnf_pkg::COUNT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                prnf_pkg::REG_RANGE: range_reg <= pwdata[prnf_pkg::RANGE_W-1:0];
                prnf_pkg::REG_COUNT: count_reg <= pwdata[prnf_pkg::COUNT_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            prnf_pkg::REG_RANGE: prdata = prnf_pkg::DATA_W'(range_reg);
            prnf_pkg::REG_COUNT: prdata = prnf_pkg::DATA_W'(count_reg);
        endcase
    end

    // ---------------- request decode ----------------
    state_t                     state_reg, state_next;
    logic                       accept;
    logic                       upd_en;
    logic                       tick;
    logic [prnf_pkg::IDX_W-1:0] wr_idx;
    prnf_pkg::pos_t             pos_in;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start & ~busy;
    assign tick   = accept & (cmd.opcode == prnf_pkg::OP_TICK);
    // ids past the table are dropped
    assign upd_en = accept & (cmd.opcode == prnf_pkg::OP_UPDATE)
                  & (32'(cmd.node_id) < 32'(prnf_pkg::NUM_DRONES));
    assign wr_idx = prnf_pkg::IDX_W'(cmd.node_id);

    // input is 24-bit two's complement, kept at table width
    assign pos_in.x = prnf_pkg::POS_BITS'($signed(cmd.pos_x));
    assign pos_in.y = prnf_pkg::POS_BITS'($signed(cmd.pos_y));
    assign pos_in.z = prnf_pkg::POS_BITS'($signed(cmd.pos_z));

    // ---------------- valid marks ----------------
    logic [prnf_pkg::NUM_DRONES-1:0] vmark_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vmark_reg <= '0;
        else if (upd_en)
            vmark_reg[wr_idx] <= (cmd.msg_seq != '0);
    end

    // ---------------- position memory: 1 write, 2 reads ----------------
    logic [prnf_pkg::IDX_W-1:0] i_reg, i_next;
    logic [prnf_pkg::IDX_W-1:0] j_reg, j_next;
    prnf_pkg::pos_t             pos_mem [prnf_pkg::NUM_DRONES];
    prnf_pkg::pos_t             rd_a_reg, rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (upd_en)
            pos_mem[wr_idx] <= pos_in;
        rd_a_reg <= pos_mem[i_reg];
        rd_b_reg <= pos_mem[j_reg];
    end

    // ---------------- scan sequencer ----------------
    logic [prnf_pkg::CNT_W-1:0] n_reg, n_next;
    logic [prnf_pkg::CNT_W-1:0] n_clip;
    logic                       i_end, j_end;
    logic                       issue, closing;
    prnf_pkg::tag_t             tag0_reg, tag0_next;
    prnf_pkg::tag_t             tag_out;
    logic                       near;
    logic                       strobe_reg, strobe_next;
    prnf_pkg::res_t             res_reg, res_next;

    // counts above the table size act as the table size
    assign n_clip = (count_reg > prnf_pkg::COUNT_W'(prnf_pkg::NUM_DRONES))
                  ? prnf_pkg::CNT_W'(prnf_pkg::NUM_DRONES)
                  : prnf_pkg::CNT_W'(count_reg);

    assign i_end = (prnf_pkg::CNT_W'(i_reg) + prnf_pkg::CNT_W'(1)) == n_reg;
    assign j_end = (prnf_pkg::CNT_W'(j_reg) + prnf_pkg::CNT_W'(1)) == n_reg;

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        n_next     = n_reg;
        issue      = 1'b0;
        closing    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick)
                begin
                    n_next     = n_clip;
                    i_next     = '0;
                    j_next     = '0;
                    state_next = (n_clip == '0) ? ST_CLOSE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                issue = 1'b1;
                if (j_end)
                begin
                    if (i_end)
                        state_next = ST_CLOSE;
                    else
                    begin
                        i_next = i_reg + prnf_pkg::IDX_W'(1);
                        j_next = i_reg + prnf_pkg::IDX_W'(1);
                    end
                end
                else
                    j_next = j_reg + prnf_pkg::IDX_W'(1);
            end
            ST_CLOSE:
            begin
                closing    = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                // closing token leaves the pipe
                if (tag_out.live && tag_out.last)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // tag lines up with the memory read data of the same edge
    always_comb
    begin
        tag0_next.live   = issue | closing;
        tag0_next.last   = closing;
        tag0_next.both   = issue & vmark_reg[i_reg] & vmark_reg[j_reg];
        tag0_next.first  = i_reg;
        tag0_next.second = j_reg;
    end

    always_comb
    begin
        strobe_next          = tag_out.live & (tag_out.last | (tag_out.both & near));
        res_next.first_id    = tag_out.last ? '0 : prnf_pkg::ID_W'(tag_out.first);
        res_next.second_id   = tag_out.last ? '0 : prnf_pkg::ID_W'(tag_out.second);
        res_next.pair_valid  = ~tag_out.last;
        res_next.last        = tag_out.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            i_reg      <= '0;
            j_reg      <= '0;
            n_reg      <= '0;
            tag0_reg   <= '0;
            strobe_reg <= 1'b0;
            res_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            n_reg      <= n_next;
            tag0_reg   <= tag0_next;
            strobe_reg <= strobe_next;
            res_reg    <= res_next;
        end
    end

    prnf_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .pos_a    (rd_a_reg),
        .pos_b    (rd_b_reg),
        .tag_in   (tag0_reg),
        .range_sq (range_reg),
        .tag_out  (tag_out),
        .near     (near)
    );

    assign result_strobe = strobe_reg;
    assign result        = res_reg;

    // ---------------- assertions ----------------
    `PRNF_ASSERT_SAME(a_pair_in_scan, result_strobe && result.pair_valid, busy,
        "pair result outside a scan")
    `PRNF_ASSERT_SAME(a_pair_order, result_strobe && result.pair_valid,
        result.first_id <= result.second_id, "pair ids out of order")
    `PRNF_ASSERT_NEXT(a_tick_busy, start && !busy && cmd.opcode == prnf_pkg::OP_TICK,
        busy, "tick request did not start a scan")
    `PRNF_ASSERT_SAME(a_close_idle, result_strobe && result.last, !busy,
        "closing result while scan still running")

endmodule

`default_nettype wire
